// ----- sv/qrp_pkg.sv -----
// Shared types, constants and functions for the quaternion to roll/pitch pipeline.
`timescale 1ns / 1ps
`default_nettype none
package qrp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CordicN       = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SQRT_STEPS    = 31;
  localparam int SW            = 62;   // square root working width
  localparam int CW            = 37;   // CORDIC x/y width
  localparam int ZW            = 26;   // CORDIC angle width, 1/65536 degree
  localparam int OPW           = 35;   // CORDIC operand width before prerotation

  localparam logic signed [ZW-1:0] DEG90   = ZW'(90 * 65536);
  localparam logic signed [17:0]   ROLL_LIM  = 18'sd46080;
  localparam logic signed [17:0]   PITCH_LIM = 18'sd23040;

  localparam logic [21:0] ATAN_TAB [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
    22'd1, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
  };

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    atan_entry = $signed({{(ZW-22){1'b0}}, ATAN_TAB[i]});
  endfunction

  // round half up to 1/256 degree, then saturate to +-lim
  function automatic logic signed [17:0] deg256(input logic signed [ZW-1:0] z,
                                                 input logic signed [17:0] lim);
    logic signed [ZW:0]   t;
    logic signed [ZW-8:0] r;
    logic signed [ZW-8:0] l;
    t = {z[ZW-1], z} + (ZW+1)'(128);
    r = t[ZW:8];
    l = (ZW-7)'(lim);
    if (r > l) r = l;
    if (r < -l) r = -l;
    deg256 = r[17:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/quaternion_to_roll_pitch.sv -----
// Top level: quaternion x/y/z to rebuilt w, roll and pitch through sqrt and CORDIC cell chains.
// Throughput: one item per cycle while the pipeline is not stalled.
// It holds two 31-cell square root chains and two CORDIC chains.
// The whole pipeline advances when the output register is empty or being taken.
// Reset clears all stage valid bits and the output valid; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_roll_pitch (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               read_ok_i,
  input  wire logic               has_quat_i,
  input  wire logic signed [31:0] quat_x_i,
  input  wire logic signed [31:0] quat_y_i,
  input  wire logic signed [31:0] quat_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    updated_o,
  output logic signed [16:0]      roll_angle_o,
  output logic signed [15:0]      pitch_angle_o,
  output logic [30:0]             quat_w_o
);

  localparam int SN  = qrp_pkg::SQRT_STEPS;
  localparam int CN  = qrp_pkg::CordicN;
  localparam int OPW = qrp_pkg::OPW;
  localparam int CW  = qrp_pkg::CW;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [OPW-1:0] den;
  } side1_t;

  typedef struct packed {
    logic               ok;
    logic [30:0]        w;
    logic signed [OPW-1:0] num;
    logic signed [OPW-1:0] den;
    logic signed [31:0] s30;
  } side2_t;

  typedef struct packed {
    logic        ok;
    logic [30:0] w;
    logic        zr_r;
    logic        zr_p;
  } side3_t;

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 0: input register
  logic               v0_q, ok0_q;
  logic signed [31:0] x0_q, y0_q, z0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok0_q <= read_ok_i & has_quat_i;
      x0_q  <= quat_x_i;
      y0_q  <= quat_y_i;
      z0_q  <= quat_z_i;
    end
  end

  // stage 1: squares
  logic               v1_q, ok1_q;
  logic signed [31:0] x1_q, y1_q, z1_q;
  logic [63:0]        sx1_q, sy1_q, sz1_q;
  logic signed [63:0] px, py, pz;
  assign px = x0_q * x0_q;
  assign py = y0_q * y0_q;
  assign pz = z0_q * z0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok1_q <= ok0_q;
      x1_q  <= x0_q;
      y1_q  <= y0_q;
      z1_q  <= z0_q;
      sx1_q <= $unsigned(px);
      sy1_q <= $unsigned(py);
      sz1_q <= $unsigned(pz);
    end
  end

  // stage 2: w radicand and roll denominator
  logic               v2_q;
  side1_t             sd2_q;
  logic [qrp_pkg::SW-1:0] rad2_q;
  logic [63:0]        ssum, sxy;
  logic signed [65:0] dfull, dsh;
  localparam logic [63:0] ONE60 = 64'd1 << 60;
  assign ssum  = sx1_q + sy1_q + sz1_q;
  assign sxy   = sx1_q + sy1_q;
  assign dfull = $signed(66'd1 << 59) - $signed({2'b00, sxy});
  assign dsh   = dfull >>> 30;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd2_q.ok  <= ok1_q;
      sd2_q.x   <= x1_q;
      sd2_q.y   <= y1_q;
      sd2_q.z   <= z1_q;
      sd2_q.den <= dsh[OPW-1:0];
      rad2_q    <= (ssum < ONE60) ? qrp_pkg::SW'(ONE60 - ssum) : '0;
    end
  end

  // square root chain for w
  qrp_pkg::sqrt_t sa_q [SN];
  side1_t         s1_q [SN];
  logic [SN-1:0]  vs1_q;
  for (genvar k = 0; k < SN; k++) begin : g_sqrt1
    qrp_pkg::sqrt_t din;
    if (k == 0) begin : g_first
      assign din = '{rem: rad2_q, res: '0};
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vs1_q[k] <= 1'b0;
        else if (en) vs1_q[k] <= v2_q;
      end
      always_ff @(posedge clk_i) begin
        if (en) s1_q[k] <= sd2_q;
      end
    end else begin : g_rest
      assign din = sa_q[k-1];
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vs1_q[k] <= 1'b0;
        else if (en) vs1_q[k] <= vs1_q[k-1];
      end
      always_ff @(posedge clk_i) begin
        if (en) s1_q[k] <= s1_q[k-1];
      end
    end
    qrp_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .step_i(5'(k)),
      .d_i   (din),
      .q_o   (sa_q[k])
    );
  end

  // stage M: products with w
  logic [30:0]        w1;
  logic signed [32:0] ws;
  logic signed [64:0] wxf, wyf, yzf, zxf;
  side1_t             t1;
  assign w1  = sa_q[SN-1].res[30:0];
  assign t1  = s1_q[SN-1];
  assign ws  = $signed({2'b00, w1});
  assign wxf = ws * t1.x;
  assign wyf = ws * t1.y;
  assign yzf = t1.y * t1.z;
  assign zxf = t1.z * t1.x;

  logic               vm_q, okm_q;
  logic [30:0]        wm_q;
  logic signed [63:0] wx_q, wy_q, yz_q, zx_q;
  logic signed [OPW-1:0] denm_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else if (en) vm_q <= vs1_q[SN-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      okm_q  <= t1.ok;
      wm_q   <= w1;
      wx_q   <= wxf[63:0];
      wy_q   <= wyf[63:0];
      yz_q   <= yzf[63:0];
      zx_q   <= zxf[63:0];
      denm_q <= t1.den;
    end
  end

  // stage A: roll numerator and clamped pitch sine
  logic signed [64:0] numf, numsh, sf, sc, ssh;
  localparam logic signed [64:0] ONE59 = 65'sd1 <<< 59;
  always_comb begin
    numf  = {wx_q[63], wx_q} + {yz_q[63], yz_q};
    numsh = numf >>> 30;
    sf    = {wy_q[63], wy_q} - {zx_q[63], zx_q};
    sc    = sf;
    if (sf > ONE59) sc = ONE59;
    if (sf < -ONE59) sc = -ONE59;
    ssh   = sc >>> 29;
  end

  logic               va_q;
  side2_t             sda_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en) va_q <= vm_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sda_q.ok  <= okm_q;
      sda_q.w   <= wm_q;
      sda_q.num <= numsh[OPW-1:0];
      sda_q.den <= denm_q;
      sda_q.s30 <= ssh[31:0];
    end
  end

  // stage Q: square of pitch sine
  logic               vq_q;
  side2_t             sdq_q;
  logic [63:0]        s2_q;
  logic signed [63:0] s2f;
  assign s2f = sda_q.s30 * sda_q.s30;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vq_q <= 1'b0;
    else if (en) vq_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sdq_q <= sda_q;
      s2_q  <= $unsigned(s2f);
    end
  end

  // square root chain for pitch cosine
  logic [63:0]    rad3;
  assign rad3 = ONE60 - s2_q;
  qrp_pkg::sqrt_t sb_q [SN];
  side2_t         s2s_q [SN];
  logic [SN-1:0]  vs2_q;
  for (genvar k = 0; k < SN; k++) begin : g_sqrt2
    qrp_pkg::sqrt_t din;
    if (k == 0) begin : g_first
      assign din = '{rem: rad3[qrp_pkg::SW-1:0], res: '0};
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vs2_q[k] <= 1'b0;
        else if (en) vs2_q[k] <= vq_q;
      end
      always_ff @(posedge clk_i) begin
        if (en) s2s_q[k] <= sdq_q;
      end
    end else begin : g_rest
      assign din = sb_q[k-1];
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vs2_q[k] <= 1'b0;
        else if (en) vs2_q[k] <= vs2_q[k-1];
      end
      always_ff @(posedge clk_i) begin
        if (en) s2s_q[k] <= s2s_q[k-1];
      end
    end
    qrp_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .step_i(5'(k)),
      .d_i   (din),
      .q_o   (sb_q[k])
    );
  end

  // prerotation into the right half plane
  function automatic qrp_pkg::cordic_t prerot(input logic signed [CW-1:0] y,
                                              input logic signed [CW-1:0] x);
    qrp_pkg::cordic_t r;
    r = '{x: x, y: y, z: '0};
    if (x < 0) begin
      if (y >= 0) begin
        r.z = qrp_pkg::DEG90;
        r.x = y;
        r.y = -x;
      end else begin
        r.z = -qrp_pkg::DEG90;
        r.x = -y;
        r.y = x;
      end
    end
    prerot = r;
  endfunction

  side2_t                 t2;
  logic signed [CW-1:0]   rx, ry, px2, py2;
  assign t2  = s2s_q[SN-1];
  assign ry  = CW'(t2.num);
  assign rx  = CW'(t2.den);
  assign py2 = CW'(t2.s30);
  assign px2 = $signed({{(CW-31){1'b0}}, sb_q[SN-1].res[30:0]});

  logic               vp_q;
  side3_t             sdp_q;
  qrp_pkg::cordic_t   rp_q, pp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp_q <= 1'b0;
    else if (en) vp_q <= vs2_q[SN-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sdp_q.ok   <= t2.ok;
      sdp_q.w    <= t2.w;
      sdp_q.zr_r <= (rx == 0) && (ry == 0);
      sdp_q.zr_p <= (px2 == 0) && (py2 == 0);
      rp_q       <= prerot(ry, rx);
      pp_q       <= prerot(py2, px2);
    end
  end

  // CORDIC chains, roll and pitch side by side
  qrp_pkg::cordic_t cr_q [CN];
  qrp_pkg::cordic_t cp_q [CN];
  side3_t           s3_q [CN];
  logic [CN-1:0]    vc_q;
  for (genvar k = 0; k < CN; k++) begin : g_cordic
    qrp_pkg::cordic_t dr, dp;
    if (k == 0) begin : g_first
      assign dr = rp_q;
      assign dp = pp_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vc_q[k] <= 1'b0;
        else if (en) vc_q[k] <= vp_q;
      end
      always_ff @(posedge clk_i) begin
        if (en) s3_q[k] <= sdp_q;
      end
    end else begin : g_rest
      assign dr = cr_q[k-1];
      assign dp = cp_q[k-1];
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vc_q[k] <= 1'b0;
        else if (en) vc_q[k] <= vc_q[k-1];
      end
      always_ff @(posedge clk_i) begin
        if (en) s3_q[k] <= s3_q[k-1];
      end
    end
    qrp_cordic_cell u_roll (
      .clk_i (clk_i),
      .en_i  (en),
      .step_i(5'(k)),
      .d_i   (dr),
      .q_o   (cr_q[k])
    );
    qrp_cordic_cell u_pitch (
      .clk_i (clk_i),
      .en_i  (en),
      .step_i(5'(k)),
      .d_i   (dp),
      .q_o   (cp_q[k])
    );
  end

  // output register
  side3_t             t3;
  logic signed [17:0] roll_d, pitch_d;
  assign t3      = s3_q[CN-1];
  assign roll_d  = t3.zr_r ? '0 : qrp_pkg::deg256(cr_q[CN-1].z, qrp_pkg::ROLL_LIM);
  assign pitch_d = t3.zr_p ? '0 : qrp_pkg::deg256(cp_q[CN-1].z, qrp_pkg::PITCH_LIM);

  logic               upd_q;
  logic signed [16:0] roll_q;
  logic signed [15:0] pitch_q;
  logic [30:0]        wout_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vc_q[CN-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      upd_q   <= t3.ok;
      roll_q  <= t3.ok ? roll_d[16:0] : '0;
      pitch_q <= t3.ok ? pitch_d[15:0] : '0;
      wout_q  <= t3.ok ? t3.w : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign updated_o     = upd_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;
  assign quat_w_o      = wout_q;

  a_not_updated_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !updated_o |->
      roll_angle_o == 0 && pitch_angle_o == 0 && quat_w_o == 0)
    else $error("item without update carries nonzero results");

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quat_w_o <= 31'd1073741824)
    else $error("rebuilt w above one");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> roll_angle_o <= 17'sd46080 && roll_angle_o >= -17'sd46080)
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pitch_angle_o <= 16'sd23040 && pitch_angle_o >= -16'sd23040)
    else $error("pitch out of range");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("pipeline advance mismatch");

endmodule
`default_nettype wire

// ----- sv/qrp_sqrt_cell.sv -----
// One restoring integer square root step, registered.
`timescale 1ns / 1ps
`default_nettype none
module qrp_sqrt_cell (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [4:0]    step_i,
  input  wire qrp_pkg::sqrt_t d_i,
  output qrp_pkg::sqrt_t      q_o
);

  qrp_pkg::sqrt_t state_d, state_q;
  logic [5:0]              sh;
  logic [qrp_pkg::SW-1:0]  bitv;
  logic [qrp_pkg::SW-1:0]  trial;

  always_comb begin
    sh    = 6'd60 - {step_i, 1'b0};
    bitv  = {{(qrp_pkg::SW-1){1'b0}}, 1'b1} << sh;
    trial = d_i.res + bitv;
    if (d_i.rem >= trial) begin
      state_d.rem = d_i.rem - trial;
      state_d.res = (d_i.res >> 1) + bitv;
    end else begin
      state_d.rem = d_i.rem;
      state_d.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) state_q <= state_d;
  end

  assign q_o = state_q;

endmodule
`default_nettype wire

// ----- sv/qrp_cordic_cell.sv -----
// One CORDIC vectoring step, registered.
`timescale 1ns / 1ps
`default_nettype none
module qrp_cordic_cell (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [4:0]      step_i,
  input  wire qrp_pkg::cordic_t d_i,
  output qrp_pkg::cordic_t      q_o
);

  qrp_pkg::cordic_t state_d, state_q;
  logic signed [qrp_pkg::CW-1:0] dx, dy;
  logic signed [qrp_pkg::ZW-1:0] a;

  always_comb begin
    dx = d_i.y >>> step_i;
    dy = d_i.x >>> step_i;
    a  = qrp_pkg::atan_entry(step_i);
    if (d_i.y > 0) begin
      state_d.x = d_i.x + dx;
      state_d.y = d_i.y - dy;
      state_d.z = d_i.z + a;
    end else begin
      state_d.x = d_i.x - dx;
      state_d.y = d_i.y + dy;
      state_d.z = d_i.z - a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) state_q <= state_d;
  end

  assign q_o = state_q;

endmodule
`default_nettype wire
